>>> sv/fsbw_pkg.sv
// ----------------------------------------------------------------------------
// fsbw_pkg
// Shared types, register codes and reset values for the black-and-white
// error-diffusion dither.
// ----------------------------------------------------------------------------
package fsbw_pkg;

   // default row store size in pixels
   localparam int MAX_WIDTH_DEF = 2048;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ERROR_GAIN      = 2'd2;

   localparam logic [11:0] IMAGE_WIDTH_RST     = 12'd640;
   localparam logic [7:0]  LEVEL_THRESHOLD_RST = 8'd128;
   localparam logic [9:0]  ERROR_GAIN_RST      = 10'd333;

   // diffused error width
   localparam int ERR_BITS = 14;

   // output levels
   localparam logic [7:0] LEVEL_WHITE = 8'd255;
   localparam logic [7:0] LEVEL_BLACK = 8'd0;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       start_of_frame;
   } fsbw_req_type;

   typedef struct packed {
      logic [7:0] bw_level;
      logic       end_of_row;
   } fsbw_rsp_type;

   typedef struct packed {
      logic [11:0] image_width;
      logic [7:0]  level_threshold;
      logic [9:0]  error_gain;
   } fsbw_cfg_type;

   // classified pixel handed from front to back (column travels beside it)
   typedef struct packed {
      logic [7:0] gray;
      logic       last;
      logic       sof;
   } fsbw_item_type;

   // floor((r+g+b)/3) by reciprocal multiply, exact for sums below 2048
   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [9:0]  total;
      logic [19:0] scaled;
      total   = {2'b00, r} + {2'b00, g} + {2'b00, b};
      scaled  = 20'(total) * 20'd683;
      gray_of = scaled[18:11];
   endfunction

endpackage

>>> sv/fsbw_front.sv
// ----------------------------------------------------------------------------
// fsbw_front
// Accepts pixels, converts them to gray and tags each with its column and
// the end-of-row flag.
// ----------------------------------------------------------------------------
module fsbw_front #(
   parameter int MAX_WIDTH = fsbw_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsbw_pkg::fsbw_cfg_type        cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fsbw_pkg::fsbw_req_type        req_payload,
   output logic                          push_valid,
   input  logic                          push_ready,
   output fsbw_pkg::fsbw_item_type       push_item,
   output logic [$clog2(MAX_WIDTH)-1:0]  push_col
);
   import fsbw_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WB = (CB + 1 > 12) ? CB + 1 : 12;
   localparam logic [WB-1:0] MAX_W = WB'(MAX_WIDTH);

   logic [WB-1:0] width_raw;
   logic [WB-1:0] width_eff;
   logic [CB-1:0] count_ff;
   logic [CB-1:0] count_in;
   logic [CB-1:0] col;
   logic          last;
   logic          accept;

   // handshake passes straight through to the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   // effective row width: zero acts as one, clamp to the row store
   always_comb begin
      width_raw = WB'(cfg.image_width);
      if (width_raw == '0) begin
         width_eff = WB'(1);
      end else if (width_raw > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = width_raw;
      end
   end

   // column of this pixel and end-of-row decision
   always_comb begin
      col = req_payload.start_of_frame ? '0 : count_ff;
      if (WB'(col) >= width_eff) begin
         col = CB'(width_eff - WB'(1));
      end
      last = (WB'(col) + WB'(1)) >= width_eff;
   end

   // column counter
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last ? '0 : col + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // item to the back part
   always_comb begin
      push_item.gray = gray_of(req_payload.red, req_payload.green, req_payload.blue);
      push_item.last = last;
      push_item.sof  = req_payload.start_of_frame;
      push_col       = col;
   end

endmodule

>>> sv/fsbw_queue.sv
// ----------------------------------------------------------------------------
// fsbw_queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module fsbw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = fsbw_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import fsbw_pkg::*;

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NB = $clog2(DEPTH + 1);
   localparam logic [PB-1:0] LAST_SLOT = PB'(DEPTH - 1);
   localparam logic [NB-1:0] FULL      = NB'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PB-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/fsbw_back.sv
// ----------------------------------------------------------------------------
// fsbw_back
// Adds the diffused error, thresholds, spreads the scaled error to the
// neighbours and keeps the next-row error store in two column banks.
// ----------------------------------------------------------------------------
module fsbw_back #(
   parameter int MAX_WIDTH = fsbw_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsbw_pkg::fsbw_cfg_type        cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  fsbw_pkg::fsbw_item_type       pop_item,
   input  logic [$clog2(MAX_WIDTH)-1:0]  pop_col,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fsbw_pkg::fsbw_rsp_type        rsp_payload
);
   import fsbw_pkg::*;

   localparam int CB         = $clog2(MAX_WIDTH);
   localparam int BAW        = CB - 1;
   localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int HB         = CB + 1;

   // even and odd column banks of the next-row error store
   logic [ERR_BITS-1:0] bank_even_mem [BANK_DEPTH];
   logic [ERR_BITS-1:0] bank_odd_mem  [BANK_DEPTH];

   // execute stage
   logic                exec_valid_ff, exec_valid_in;
   fsbw_item_type       exec_item_ff, exec_item_in;
   logic [CB-1:0]       exec_col_ff, exec_col_in;
   logic                rd_zero_ff, rd_zero_in;
   logic                rd_byp_ff, rd_byp_in;
   logic [ERR_BITS-1:0] rd_byp_data_ff, rd_byp_data_in;
   logic [ERR_BITS-1:0] rd_even_ff;
   logic [ERR_BITS-1:0] rd_odd_ff;

   // stream state
   logic signed [ERR_BITS-1:0] right_err_ff, right_err_in;
   logic signed [ERR_BITS-1:0] bl_pend_ff, bl_pend_in;
   logic signed [ERR_BITS-1:0] b_pend_ff, b_pend_in;
   logic [HB-1:0]              fill_ff, fill_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   fsbw_rsp_type rsp_payload_ff, rsp_payload_in;

   logic commit;
   logic pop;

   logic signed [ERR_BITS-1:0] row_err;
   logic signed [ERR_BITS-1:0] re, blp, bp;
   logic [15:0]                sum_raw;
   logic [7:0]                 corr;
   logic [7:0]                 outv;
   logic signed [8:0]          err;
   logic signed [19:0]         prod;
   logic signed [22:0]         p23, p7, p5, p3;
   logic signed [ERR_BITS-1:0] e_right, e_bl, e_b, e_br;
   logic signed [ERR_BITS-1:0] bl_wr, blp_new;

   logic                wa_en, wb_en;
   logic [CB-1:0]       wa_col;
   logic                even_we, odd_we;
   logic [BAW-1:0]      even_addr, odd_addr;
   logic [ERR_BITS-1:0] even_data, odd_data;
   logic [HB-1:0]       fill_base, fill_cand;

   // floor of x / 4096
   function automatic logic signed [ERR_BITS-1:0] share_of(input logic signed [22:0] x);
      share_of = {{3{x[22]}}, x[22:12]};
   endfunction

   // stage handshakes
   assign commit    = exec_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign pop_ready = ~exec_valid_ff | commit;
   assign pop       = pop_valid & pop_ready;

   // error from the row above, gated by fill mark and write bypass
   always_comb begin
      if (rd_zero_ff) begin
         row_err = '0;
      end else if (rd_byp_ff) begin
         row_err = rd_byp_data_ff;
      end else begin
         row_err = exec_col_ff[0] ? rd_odd_ff : rd_even_ff;
      end
      re  = exec_item_ff.sof ? '0 : right_err_ff;
      blp = exec_item_ff.sof ? '0 : bl_pend_ff;
      bp  = exec_item_ff.sof ? '0 : b_pend_ff;
   end

   // corrected gray, threshold and signed error
   always_comb begin
      sum_raw = {8'd0, exec_item_ff.gray} + {{2{re[ERR_BITS-1]}}, re}
              + {{2{row_err[ERR_BITS-1]}}, row_err};
      if (sum_raw[15]) begin
         corr = 8'd0;
      end else if (sum_raw[14:8] != '0) begin
         corr = 8'd255;
      end else begin
         corr = sum_raw[7:0];
      end
      outv = (corr > cfg.level_threshold) ? LEVEL_WHITE : LEVEL_BLACK;
      err  = $signed({1'b0, corr}) - $signed({1'b0, outv});
   end

   // gain scaling and the four shares
   always_comb begin
      prod    = 20'(err) * 20'($signed({1'b0, cfg.error_gain}));
      p23     = {{3{prod[19]}}, prod};
      p7      = (p23 <<< 3) - p23;
      p5      = (p23 <<< 2) + p23;
      p3      = (p23 <<< 1) + p23;
      e_right = share_of(p7);
      e_bl    = share_of(p3);
      e_b     = share_of(p5);
      e_br    = share_of(p23);
      bl_wr   = blp + e_bl;
      blp_new = bp + e_b;
   end

   // store writes: below-left of this pixel and, at row end, this column
   always_comb begin
      wa_en  = commit && (exec_col_ff != '0);
      wa_col = exec_col_ff - CB'(1);
      wb_en  = commit && exec_item_ff.last;

      even_we   = (wa_en && !wa_col[0]) || (wb_en && !exec_col_ff[0]);
      odd_we    = (wa_en && wa_col[0]) || (wb_en && exec_col_ff[0]);
      even_addr = (wa_en && !wa_col[0]) ? wa_col[CB-1:1] : exec_col_ff[CB-1:1];
      odd_addr  = (wa_en && wa_col[0]) ? wa_col[CB-1:1] : exec_col_ff[CB-1:1];
      even_data = (wa_en && !wa_col[0]) ? bl_wr : blp_new;
      odd_data  = (wa_en && wa_col[0]) ? bl_wr : blp_new;
   end

   // fill mark: columns below it were written since frame start
   always_comb begin
      fill_base = exec_item_ff.sof ? '0 : fill_ff;
      fill_cand = exec_item_ff.last ? HB'(exec_col_ff) + HB'(1) : HB'(exec_col_ff);
      fill_in   = fill_ff;
      if (commit) begin
         fill_in = (fill_cand > fill_base) ? fill_cand : fill_base;
      end
   end

   // read setup for the item entering the execute stage
   always_comb begin
      rd_zero_in     = pop_item.sof || !(HB'(pop_col) < fill_in);
      rd_byp_in      = pop_col[0] ? (odd_we && odd_addr == pop_col[CB-1:1])
                                  : (even_we && even_addr == pop_col[CB-1:1]);
      rd_byp_data_in = pop_col[0] ? odd_data : even_data;
      exec_item_in   = pop_item;
      exec_col_in    = pop_col;
      exec_valid_in  = pop ? 1'b1 : (commit ? 1'b0 : exec_valid_ff);
   end

   // stream state update
   always_comb begin
      right_err_in = right_err_ff;
      bl_pend_in   = bl_pend_ff;
      b_pend_in    = b_pend_ff;
      if (commit) begin
         if (exec_item_ff.last) begin
            right_err_in = '0;
            bl_pend_in   = '0;
            b_pend_in    = '0;
         end else begin
            right_err_in = e_right;
            bl_pend_in   = blp_new;
            b_pend_in    = e_br;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (commit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.bw_level   = outv;
         rsp_payload_in.end_of_row = exec_item_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         right_err_ff  <= '0;
         bl_pend_ff    <= '0;
         b_pend_ff     <= '0;
         fill_ff       <= '0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         right_err_ff  <= right_err_in;
         bl_pend_ff    <= bl_pend_in;
         b_pend_ff     <= b_pend_in;
         fill_ff       <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (pop) begin
         exec_item_ff   <= exec_item_in;
         exec_col_ff    <= exec_col_in;
         rd_zero_ff     <= rd_zero_in;
         rd_byp_ff      <= rd_byp_in;
         rd_byp_data_ff <= rd_byp_data_in;
      end
   end

   // even bank
   always_ff @(posedge clock) begin
      if (even_we) begin
         bank_even_mem[even_addr] <= even_data;
      end
      if (pop) begin
         rd_even_ff <= bank_even_mem[pop_col[CB-1:1]];
      end
   end

   // odd bank
   always_ff @(posedge clock) begin
      if (odd_we) begin
         bank_odd_mem[odd_addr] <= odd_data;
      end
      if (pop) begin
         rd_odd_ff <= bank_odd_mem[pop_col[CB-1:1]];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> sv/floyd_steinberg_bw_dither.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_bw_dither
// Black-and-white error-diffusion dither of an RGB pixel stream in raster
// order, with gain-scaled 7/3/5/1 sixteenths spread to the neighbours.
//
//   channel   ports          direction  contents
//   request   req_*          in         red, green, blue, start_of_frame
//   response  rsp_*          out        bw_level, end_of_row
//   csr       csr_*          in         image_width, level_threshold, error_gain
//
// One item per clock sustained while neither side stalls; an accepted item
// passes the queue, pops into the execute stage with the row store read,
// then moves from execute into the output register that drives rsp_valid.
// The rate is set by the right-neighbour error loop, closed in the single
// execute stage of the back part; the row store is split into even and odd
// column banks so both error writes of a row end land in the same cycle.
// Reset is synchronous; no clearing pass: a fill mark tracks which columns
// were written since frame start, and unwritten columns read as zero.
// Either side may stall; the queue and output register hold items meanwhile.
// ----------------------------------------------------------------------------
module floyd_steinberg_bw_dither #(
   parameter int MAX_WIDTH = fsbw_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fsbw_pkg::fsbw_req_type                req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fsbw_pkg::fsbw_rsp_type                rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [fsbw_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fsbw_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import fsbw_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int QW = $bits(fsbw_item_type) + CB;

   fsbw_cfg_type  cfg_ff, cfg_in;

   logic          push_valid, push_ready;
   fsbw_item_type push_item;
   logic [CB-1:0] push_col;
   logic          pop_valid, pop_ready;
   fsbw_item_type pop_item;
   logic [CB-1:0] pop_col;
   logic [QW-1:0] pop_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_write_data;
            end
            CSR_LEVEL_THRESHOLD: begin
               cfg_in.level_threshold = csr_write_data[7:0];
            end
            CSR_ERROR_GAIN: begin
               cfg_in.error_gain = csr_write_data[9:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= IMAGE_WIDTH_RST;
         cfg_ff.level_threshold <= LEVEL_THRESHOLD_RST;
         cfg_ff.error_gain      <= ERROR_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   fsbw_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item),
      .push_col    (push_col)
   );

   // queue between front and back
   fsbw_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_item, push_col}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_item = pop_data[QW-1:CB];
   assign pop_col  = pop_data[CB-1:0];

   // back: diffuse and deliver
   fsbw_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .pop_col     (pop_col),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no result pending right after reset
   a_idle_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // empty queue takes an item right after reset
   a_ready_after_reset: assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("request not ready right after reset");

   // dithered level is pure black or pure white
   a_level_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.bw_level == LEVEL_WHITE ||
                     rsp_payload.bw_level == LEVEL_BLACK))
      else $error("result level neither black nor white");

endmodule
